>>> rtl/core/rwim_pkg.sv
// Shared constants, codes and types of the repeat window interval merger.
`default_nettype none

package rwim_pkg;

  // Field widths
  localparam int CHROM_BITS = 8;
  localparam int COUNT_BITS = 16;
  localparam int POS_BITS   = 31;
  localparam int LEN_BITS   = 32;
  localparam int THR_BITS   = 17;
  localparam int FRAC_BITS  = 16;
  localparam int TOT_BITS   = COUNT_BITS + 1;
  localparam int PROD_BITS  = THR_BITS + TOT_BITS;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(32768);

  // Input stream packing, lowest bit first
  localparam int IN_CHROM_LSB = 0;
  localparam int IN_START_LSB = IN_CHROM_LSB + CHROM_BITS;
  localparam int IN_END_LSB   = IN_START_LSB + POS_BITS;
  localparam int IN_DISC_LSB  = IN_END_LSB + POS_BITS;
  localparam int IN_REP_LSB   = IN_DISC_LSB + COUNT_BITS;
  localparam int IN_USED_BITS = IN_REP_LSB + COUNT_BITS;
  localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS = 1;

  // Output stream packing, lowest bit first
  localparam int OUT_CHROM_LSB = 0;
  localparam int OUT_FIRST_LSB = OUT_CHROM_LSB + CHROM_BITS;
  localparam int OUT_LAST_LSB  = OUT_FIRST_LSB + POS_BITS;
  localparam int OUT_LEN_LSB   = OUT_LAST_LSB + POS_BITS;
  localparam int OUT_TOTAL_LSB = OUT_LEN_LSB + LEN_BITS;
  localparam int OUT_USED_BITS = OUT_TOTAL_LSB + LEN_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 2;

  // Queue between classifier and merger
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Register port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_LSB   = 2;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_UNUSED    = 1'b1
  } rwim_reg_e;

  typedef enum logic {
    ACT_WINDOW = 1'b0,
    ACT_FLUSH  = 1'b1
  } rwim_action_e;

  // Classified item held in the queue
  typedef struct packed {
    rwim_action_e          action;
    logic [CHROM_BITS-1:0] chrom;
    logic [POS_BITS-1:0]   first;
    logic [POS_BITS-1:0]   last;
  } rwim_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } rwim_qstat_t;

  typedef struct packed {
    logic                  has_region;
    logic                  is_final;
    logic [CHROM_BITS-1:0] chrom;
    logic [POS_BITS-1:0]   first;
    logic [POS_BITS-1:0]   last;
    logic [LEN_BITS-1:0]   length;
    logic [LEN_BITS-1:0]   total;
  } rwim_result_t;

endpackage

`default_nettype wire

>>> rtl/core/rwim_classify.sv
// Front end: unpack input beats, test windows for repetitiveness, push kept items.
`default_nettype none

module rwim_classify
  import rwim_pkg::*;
(
  input  wire logic [IN_DATA_BITS-1:0] s_axis_tdata_i,
  input  wire logic [IN_USER_BITS-1:0] s_axis_tuser_i,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire logic [THR_BITS-1:0]     threshold_i,
  input  wire rwim_qstat_t             qstat_i,
  output logic                         push_o,
  output rwim_item_t                   item_o
);

  logic [COUNT_BITS-1:0] disc;
  logic [COUNT_BITS-1:0] rep;
  logic [TOT_BITS-1:0]   total;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  rep_scaled;
  logic                  rep_hit;
  rwim_action_e          action;

  assign disc   = s_axis_tdata_i[IN_DISC_LSB +: COUNT_BITS];
  assign rep    = s_axis_tdata_i[IN_REP_LSB +: COUNT_BITS];
  assign action = rwim_action_e'(s_axis_tuser_i[0]);

  // rep * 2^16 >= threshold * (disc + rep), zero total never qualifies
  assign total      = TOT_BITS'(disc) + TOT_BITS'(rep);
  assign prod       = PROD_BITS'(threshold_i) * PROD_BITS'(total);
  assign rep_scaled = PROD_BITS'({rep, {FRAC_BITS{1'b0}}});
  assign rep_hit    = (total != '0) && (rep_scaled >= prod);

  assign s_axis_tready_o = !qstat_i.full;

  // drop windows that are not repetitive: they change nothing downstream
  assign push_o = s_axis_tvalid_i && !qstat_i.full && ((action == ACT_FLUSH) || rep_hit);

  assign item_o.action = action;
  assign item_o.chrom  = s_axis_tdata_i[IN_CHROM_LSB +: CHROM_BITS];
  assign item_o.first  = s_axis_tdata_i[IN_START_LSB +: POS_BITS];
  assign item_o.last   = s_axis_tdata_i[IN_END_LSB +: POS_BITS];

endmodule

`default_nettype wire

>>> rtl/core/rwim_fifo.sv
// Short queue of classified items between front and back end.
`default_nettype none

module rwim_fifo
  import rwim_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire rwim_item_t item_i,
  input  wire logic       pop_i,
  output rwim_item_t      head_o,
  output rwim_qstat_t     qstat_o
);

  rwim_item_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign qstat_o.valid = (cnt_q != '0);
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_PTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + FIFO_PTR_BITS'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FIFO_CNT_BITS'(push_i) - FIFO_CNT_BITS'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> qstat_o.valid)
    else $error("queue read while empty");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/core/rwim_merge.sv
// Back end: merge repetitive windows into regions and hold the result beat.
`default_nettype none

module rwim_merge
  import rwim_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rwim_qstat_t qstat_i,
  input  wire rwim_item_t  head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output rwim_result_t     result_o
);

  logic                  open_q, open_d;
  logic [CHROM_BITS-1:0] chrom_q, chrom_d;
  logic [POS_BITS-1:0]   first_q, first_d;
  logic [POS_BITS-1:0]   last_q, last_d;
  logic [LEN_BITS-1:0]   sum_q, sum_d;
  logic                  out_valid_q, out_valid_d;
  rwim_result_t          out_q, out_d;

  logic                  is_flush;
  logic                  hit;
  logic                  emit;
  logic [LEN_BITS-1:0]   len;
  logic [LEN_BITS-1:0]   sum_new;

  assign pop_o     = qstat_i.valid && (!out_valid_q || m_ready_i);
  assign is_flush  = (head_i.action == ACT_FLUSH);
  assign hit       = open_q && (head_i.chrom == chrom_q) && (head_i.first <= last_q);
  assign len       = open_q ? LEN_BITS'(last_q) - LEN_BITS'(first_q) + LEN_BITS'(1) : '0;
  assign sum_new   = sum_q + len;
  assign emit      = pop_o && (is_flush || (open_q && !hit));
  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

  // region state
  always_comb begin
    open_d  = open_q;
    chrom_d = chrom_q;
    first_d = first_q;
    last_d  = last_q;
    sum_d   = sum_q;
    if (pop_o) begin
      priority if (is_flush) begin
        open_d  = 1'b0;
        chrom_d = '0;
        first_d = '0;
        last_d  = '0;
        sum_d   = '0;
      end else if (hit) begin
        last_d = head_i.last;
      end else begin
        open_d  = 1'b1;
        chrom_d = head_i.chrom;
        first_d = head_i.first;
        last_d  = head_i.last;
        sum_d   = sum_new;
      end
    end
  end

  // result beat: load on emit, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.has_region = open_q;
      out_d.is_final   = is_flush;
      out_d.chrom      = open_q ? chrom_q : '0;
      out_d.first      = open_q ? first_q : '0;
      out_d.last       = open_q ? last_q : '0;
      out_d.length     = len;
      out_d.total      = sum_new;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      chrom_q     <= '0;
      first_q     <= '0;
      last_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      chrom_q     <= chrom_d;
      first_q     <= first_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_flush) |=> (!open_q && sum_q == '0))
    else $error("flush did not clear region state");

  a_window_result_has_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_final) |-> out_q.has_region)
    else $error("window result without a region");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result beat changed");

endmodule

`default_nettype wire

>>> rtl/core/repeat_window_interval_merger.sv
// Top level of the repeat window interval merger: register port, front, queue, back.
//
//  channel   | role             | handshake                  | payload
//  ----------+------------------+----------------------------+-----------------------------------
//  s_axis    | window/end beats | s_axis_tvalid/tready       | tuser: action; tdata: window fields
//  m_axis    | region results   | m_axis_tvalid/tready       | tuser: flags; tdata: region fields
//  apb       | threshold reg    | psel/penable/pwrite/pready | paddr 0: proportion_threshold
//
// One beat per cycle is taken while the four-entry queue has room; the threshold
// multiply-and-compare sits in front of the queue and the merge update behind it.
// m_axis_tvalid rises once the causing beat has passed through the queue and loaded the result register.
// A stalled m_axis holds the result register; the queue keeps taking beats until full.
// Reset clears the region state, the running length sum and sets the threshold to one half.
`default_nettype none

module repeat_window_interval_merger
  import rwim_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] chrom, [38:8] window_start, [69:39] window_end,
  // [85:70] discriminative_count, [101:86] repetitive_count, [103:102] zero
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] action
  input  wire logic [IN_USER_BITS-1:0]  s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [7:0] region_chrom, [38:8] region_first, [69:39] region_last,
  // [101:70] region_length, [133:102] total_size, [135:134] zero
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  // [0] has_region, [1] is_final
  output logic [OUT_USER_BITS-1:0]      m_axis_tuser,
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  logic [THR_BITS-1:0] thr_q, thr_d;
  rwim_reg_e           reg_idx;
  logic                reg_wr;

  rwim_qstat_t  qstat;
  rwim_item_t   push_item;
  rwim_item_t   head_item;
  logic         push;
  logic         pop;
  rwim_result_t result;

  // Register port: no wait states, word index from paddr above the byte offset
  assign pready  = 1'b1;
  assign reg_idx = rwim_reg_e'(paddr[REG_IDX_LSB]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    thr_d = thr_q;
    if (reg_wr && (reg_idx == REG_THRESHOLD)) begin
      thr_d = pwdata[THR_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_BITS'(thr_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  // Front: classify and drop non-repetitive windows
  rwim_classify u_classify (
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .threshold_i     (thr_q),
    .qstat_i         (qstat),
    .push_o          (push),
    .item_o          (push_item)
  );

  rwim_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .qstat_o (qstat)
  );

  // Back: merge regions and own the result register
  rwim_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qstat_i   (qstat),
    .head_i    (head_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (result)
  );

  always_comb begin
    m_axis_tdata                                 = '0;
    m_axis_tdata[OUT_CHROM_LSB +: CHROM_BITS]    = result.chrom;
    m_axis_tdata[OUT_FIRST_LSB +: POS_BITS]      = result.first;
    m_axis_tdata[OUT_LAST_LSB +: POS_BITS]       = result.last;
    m_axis_tdata[OUT_LEN_LSB +: LEN_BITS]        = result.length;
    m_axis_tdata[OUT_TOTAL_LSB +: LEN_BITS]      = result.total;
    m_axis_tuser                                 = {result.is_final, result.has_region};
  end

endmodule

`default_nettype wire
